FILE: src/diagnostic_probe_sequencer_macros.svh
// Assertion macros for the diagnostic probe sequencer.
// Used by modules that have i_clk and i_rst_n (synchronous, active low) in scope.
`ifndef DIAGNOSTIC_PROBE_SEQUENCER_MACROS_SVH
`define DIAGNOSTIC_PROBE_SEQUENCER_MACROS_SVH

// Condition holds at every edge outside reset
`define DPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define DPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define DPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dps_pkg.sv
// Shared types and constants of the diagnostic probe sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package dps_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;  // reserved, ignored by the survey

    // Command kinds
    localparam logic [1:0] CMD_SET_HEADER = 2'd0;
    localparam logic [1:0] CMD_TESTER     = 2'd1;
    localparam logic [1:0] CMD_PID_QUERY  = 2'd2;
    localparam logic [1:0] CMD_LOCAL_ID   = 2'd3;

    // Survey phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SWEEP = 3'd1;
    localparam logic [2:0] PH_WALK  = 3'd2;
    localparam logic [2:0] PH_LOCAL = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // Survey constants
    localparam logic [3:0]  PROBE_HEADERS  = 4'd8;
    localparam logic [7:0]  PID_BLOCK_STEP = 8'h20;
    localparam logic [7:0]  PID_BLOCK_LAST = 8'hE0;
    localparam logic [8:0]  LOCAL_ID_LAST  = 9'h0FF;
    localparam logic [10:0] HEADER_RESET   = 11'h7E0;
    localparam int          MAX_ECUS_DEF   = 8;

    typedef struct packed {
        logic [1:0] kind;
        logic       owns_channel;
        logic       reply_pending;
        logic       reply_timed_out;
        logic       reply_answered;
    } t_item;

    typedef struct packed {
        logic        send_command;
        logic [1:0]  command_kind;
        logic [10:0] header;
        logic [7:0]  argument;
        logic        expire_reply;
        logic [2:0]  phase;
        logic        running;
        logic [3:0]  found_count;
    } t_result;

endpackage

`default_nettype wire

FILE: src/diagnostic_probe_sequencer.sv
// Top level of the diagnostic probe sequencer: input register, step core, result register.
// Depends on dps_pkg, dps_in_stage, dps_core and dps_out_stage.
//
//   channel   direction  handshake            payload
//   item in   input      i_valid / o_ready    i_kind .. i_reply_answered
//   result    output     o_valid / i_ready    o_send_command .. o_found_count
//   config    input      i_cfg_we             i_cfg_data (header base)
//
// One item per cycle sustained while results are taken; an accepted item's result goes
// through the input register and then the result register before it is on the outputs.
// The survey state updates when an item moves from the input register to the result
// register, so the step logic is the only path between the two.
// A stalled result holds while one more item waits in the input register.
// Reset (i_rst_n low at a clock edge) empties both registers and sets the header
// base to 0x7E0 and the survey to idle.
`default_nettype none

module diagnostic_probe_sequencer
    import dps_pkg::*;
#(
    parameter int MAX_ECUS = MAX_ECUS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_owns_channel,
    input  wire logic        i_reply_pending,
    input  wire logic        i_reply_timed_out,
    input  wire logic        i_reply_answered,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_send_command,
    output logic [1:0]       o_command_kind,
    output logic [10:0]      o_header,
    output logic [7:0]       o_argument,
    output logic             o_expire_reply,
    output logic [2:0]       o_phase,
    output logic             o_running,
    output logic [3:0]       o_found_count
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    step;
    t_result step_res;
    t_result out_res;

    assign in_item.kind            = i_kind;
    assign in_item.owns_channel    = i_owns_channel;
    assign in_item.reply_pending   = i_reply_pending;
    assign in_item.reply_timed_out = i_reply_timed_out;
    assign in_item.reply_answered  = i_reply_answered;

    // Item moves to the result register when that has room
    assign step = held_valid && out_free;

    dps_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    dps_core #(
        .MAX_ECUS (MAX_ECUS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_item     (held_item),
        .o_result   (step_res)
    );

    dps_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (step_res),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_res)
    );

    assign o_send_command = out_res.send_command;
    assign o_command_kind = out_res.command_kind;
    assign o_header       = out_res.header;
    assign o_argument     = out_res.argument;
    assign o_expire_reply = out_res.expire_reply;
    assign o_phase        = out_res.phase;
    assign o_running      = out_res.running;
    assign o_found_count  = out_res.found_count;

endmodule

`default_nettype wire

FILE: src/dps_in_stage.sv
// Input register of the diagnostic probe sequencer.
// Depends on dps_pkg (t_item).
`default_nettype none

module dps_in_stage
    import dps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held item moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/dps_out_stage.sv
// Result register of the diagnostic probe sequencer.
// Depends on dps_pkg (t_result).
`default_nettype none

module dps_out_stage
    import dps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // Room for a new item when empty or when the held one leaves now
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: src/dps_core.sv
// Survey state and combinational step logic of the diagnostic probe sequencer.
// Depends on dps_pkg and diagnostic_probe_sequencer_macros.svh.
`default_nettype none

`include "diagnostic_probe_sequencer_macros.svh"

module dps_core
    import dps_pkg::*;
#(
    parameter int MAX_ECUS = MAX_ECUS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_step,
    input  wire t_item       i_item,
    output t_result          o_result
);

    localparam int         IDX_W     = (MAX_ECUS > 1) ? $clog2(MAX_ECUS) : 1;
    localparam logic [3:0] FOUND_MAX = 4'(MAX_ECUS);

    // Configuration
    logic [10:0] r_header_base;

    // Survey state
    logic [2:0] r_phase,         n_phase;
    logic [3:0] r_probe_index,   n_probe_index;
    logic [3:0] r_found_total,   n_found_total;
    logic [3:0] r_walk_pos,      n_walk_pos;
    logic [7:0] r_pid_block,     n_pid_block;
    logic [3:0] r_sweep_pos,     n_sweep_pos;
    logic [8:0] r_local_id,      n_local_id;
    logic       r_header_known,  n_header_known;
    logic [2:0] r_header_cached, n_header_cached;
    logic       r_awaiting,      n_awaiting;
    logic       r_awaiting_probe, n_awaiting_probe;

    // Found-offset store, written only during the header sweep
    logic [2:0] r_found [MAX_ECUS];

    logic             w_en;
    logic [IDX_W-1:0] w_idx;
    logic [2:0]       w_data;

    // Step scratch
    logic       v_pend;
    logic       v_go;
    logic [1:0] v_want;
    logic [2:0] v_off;
    logic [7:0] v_arg;
    logic [3:0] v_rd_pos;
    t_result    n_res;

    assign o_result = n_res;

    // One item: start/stop/tick, completion, then the phase action
    always_comb begin
        n_phase          = r_phase;
        n_probe_index    = r_probe_index;
        n_found_total    = r_found_total;
        n_walk_pos       = r_walk_pos;
        n_pid_block      = r_pid_block;
        n_sweep_pos      = r_sweep_pos;
        n_local_id       = r_local_id;
        n_header_known   = r_header_known;
        n_header_cached  = r_header_cached;
        n_awaiting       = r_awaiting;
        n_awaiting_probe = r_awaiting_probe;
        w_en             = 1'b0;
        w_idx            = r_found_total[IDX_W-1:0];
        w_data           = r_probe_index[2:0];
        v_pend           = i_item.reply_pending;
        v_go             = 1'b0;
        v_want           = CMD_SET_HEADER;
        v_off            = 3'd0;
        v_arg            = 8'd0;
        v_rd_pos         = 4'd0;
        n_res            = '0;

        case (i_item.kind)
            KIND_START: begin
                n_probe_index    = 4'd0;
                n_found_total    = 4'd0;
                n_walk_pos       = 4'd0;
                n_pid_block      = 8'd0;
                n_sweep_pos      = 4'd0;
                n_local_id       = 9'd0;
                n_header_known   = 1'b0;
                n_header_cached  = 3'd0;
                n_awaiting       = 1'b0;
                n_awaiting_probe = 1'b0;
                n_phase          = PH_SWEEP;
            end
            KIND_STOP: begin
                n_phase = PH_IDLE;
            end
            KIND_TICK: begin
                if (i_item.owns_channel &&
                    (r_phase == PH_SWEEP || r_phase == PH_WALK || r_phase == PH_LOCAL)) begin
                    // Timeout drops the pending reply
                    if (i_item.reply_pending && i_item.reply_timed_out) begin
                        n_res.expire_reply = 1'b1;
                        v_pend             = 1'b0;
                    end
                    if (!v_pend) begin
                        // Completion of the outstanding command
                        if (r_awaiting) begin
                            n_awaiting = 1'b0;
                            if (r_awaiting_probe) begin
                                case (r_phase)
                                    PH_SWEEP: begin
                                        if (i_item.reply_answered &&
                                            r_found_total < FOUND_MAX) begin
                                            w_en          = 1'b1;
                                            n_found_total = r_found_total + 4'd1;
                                        end
                                        n_probe_index = r_probe_index + 4'd1;
                                    end
                                    PH_WALK: begin
                                        if (r_pid_block >= PID_BLOCK_LAST) begin
                                            n_pid_block = 8'd0;
                                            n_walk_pos  = r_walk_pos + 4'd1;
                                        end else begin
                                            n_pid_block = r_pid_block + PID_BLOCK_STEP;
                                        end
                                    end
                                    PH_LOCAL: begin
                                        if (r_local_id >= LOCAL_ID_LAST) begin
                                            n_local_id  = 9'd0;
                                            n_sweep_pos = r_sweep_pos + 4'd1;
                                        end else begin
                                            n_local_id = r_local_id + 9'd1;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end

                        // Phase action on the advanced positions
                        v_rd_pos = (r_phase == PH_WALK) ? n_walk_pos : n_sweep_pos;
                        case (r_phase)
                            PH_SWEEP: begin
                                if (n_probe_index >= PROBE_HEADERS) begin
                                    n_phase     = PH_WALK;
                                    n_walk_pos  = 4'd0;
                                    n_pid_block = 8'd0;
                                end else begin
                                    v_go   = 1'b1;
                                    v_want = CMD_TESTER;
                                    v_off  = n_probe_index[2:0];
                                end
                            end
                            PH_WALK: begin
                                if (n_walk_pos >= n_found_total) begin
                                    n_phase     = PH_LOCAL;
                                    n_sweep_pos = 4'd0;
                                    n_local_id  = 9'd0;
                                end else begin
                                    v_go   = 1'b1;
                                    v_want = CMD_PID_QUERY;
                                    v_off  = r_found[v_rd_pos[IDX_W-1:0]];
                                    v_arg  = n_pid_block;
                                end
                            end
                            PH_LOCAL: begin
                                if (n_sweep_pos >= n_found_total) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    v_go   = 1'b1;
                                    v_want = CMD_LOCAL_ID;
                                    v_off  = r_found[v_rd_pos[IDX_W-1:0]];
                                    v_arg  = n_local_id[7:0];
                                end
                            end
                            default: begin
                            end
                        endcase

                        // Set the header first when it differs from the cached one
                        if (v_go) begin
                            if (!(r_header_known && r_header_cached == v_off)) begin
                                n_header_known  = 1'b1;
                                n_header_cached = v_off;
                                v_want          = CMD_SET_HEADER;
                                v_arg           = 8'd0;
                            end
                            n_awaiting           = 1'b1;
                            n_awaiting_probe     = (v_want != CMD_SET_HEADER);
                            n_res.send_command   = 1'b1;
                            n_res.command_kind   = v_want;
                            n_res.header         = r_header_base + {8'd0, v_off};
                            n_res.argument       = v_arg;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        n_res.phase       = n_phase;
        n_res.running     = (n_phase == PH_SWEEP || n_phase == PH_WALK ||
                             n_phase == PH_LOCAL);
        n_res.found_count = n_found_total;
    end

    // Header base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_base <= HEADER_RESET;
        end else if (i_cfg_we) begin
            r_header_base <= i_cfg_data;
        end
    end

    // Survey state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_probe_index    <= 4'd0;
            r_found_total    <= 4'd0;
            r_walk_pos       <= 4'd0;
            r_pid_block      <= 8'd0;
            r_sweep_pos      <= 4'd0;
            r_local_id       <= 9'd0;
            r_header_known   <= 1'b0;
            r_header_cached  <= 3'd0;
            r_awaiting       <= 1'b0;
            r_awaiting_probe <= 1'b0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_probe_index    <= n_probe_index;
            r_found_total    <= n_found_total;
            r_walk_pos       <= n_walk_pos;
            r_pid_block      <= n_pid_block;
            r_sweep_pos      <= n_sweep_pos;
            r_local_id       <= n_local_id;
            r_header_known   <= n_header_known;
            r_header_cached  <= n_header_cached;
            r_awaiting       <= n_awaiting;
            r_awaiting_probe <= n_awaiting_probe;
        end
    end

    // Found-offset store write
    always_ff @(posedge i_clk) begin
        if (i_step && w_en) begin
            r_found[w_idx] <= w_data;
        end
    end

    `DPS_ASSERT_ALWAYS(a_found_bound, r_found_total <= FOUND_MAX,
        "found count exceeds MAX_ECUS")
    `DPS_ASSERT_ALWAYS(a_pid_aligned, r_pid_block[4:0] == 5'd0,
        "PID block off its 0x20 grid")
    `DPS_ASSERT_NEXT(a_start_clears, i_step && i_item.kind == KIND_START,
        r_phase == PH_SWEEP && r_found_total == 4'd0 && !r_awaiting,
        "start item did not reset the survey")
    `DPS_ASSERT_NEXT(a_send_waits, i_step && n_res.send_command, r_awaiting,
        "command sent without waiting for its reply")
    `DPS_ASSERT_SAME(a_query_header, n_res.send_command && n_res.command_kind != CMD_SET_HEADER,
        n_header_known && n_header_cached == v_off,
        "query sent to a header that is not set")

endmodule

`default_nettype wire
